// ===== hdl/xpm_pkg.sv =====
// ----------------------------------------------------------------------------
// xpm_pkg
// Shared widths, bounds and types of the binary dot-product engine.
// ----------------------------------------------------------------------------
package xpm_pkg;

   localparam int WORD_BITS = 32;
   localparam int MAX_WORDS = 4096;
   localparam int SUM_BOUND = MAX_WORDS * WORD_BITS;

   localparam int DOT_W    = 19;
   localparam int ACC_W    = DOT_W + 1;
   localparam int SCALE_W  = 16;
   localparam int SCALED_W = 34;
   localparam int PROD_W   = SCALED_W + 1;
   localparam int ONES_W   = $clog2(WORD_BITS + 1);

   typedef struct packed {
      logic                    valid;
      logic signed [DOT_W-1:0] dot_sum;
      logic [SCALE_W-1:0]      scale_q;
   } sum_stage_type;

endpackage

// ===== hdl/xpm_if.sv =====
// ----------------------------------------------------------------------------
// xpm_if
// Valid/ready channels for word items and dot-product results.
// ----------------------------------------------------------------------------
interface xpm_req_if;
   logic                               valid;
   logic                               ready;
   logic [xpm_pkg::WORD_BITS-1:0]      weight_word;
   logic [xpm_pkg::WORD_BITS-1:0]      act_word;
   logic [xpm_pkg::SCALE_W-1:0]        scale_q;
   logic                               last;

   modport source (output valid, output weight_word, output act_word,
                   output scale_q, output last, input ready);
   modport sink   (input valid, input weight_word, input act_word,
                   input scale_q, input last, output ready);
endinterface

interface xpm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [xpm_pkg::DOT_W-1:0]    dot_sum;
   logic signed [xpm_pkg::SCALED_W-1:0] scaled_result;

   modport source (output valid, output dot_sum, output scaled_result, input ready);
   modport sink   (input valid, input dot_sum, input scaled_result, output ready);
endinterface

// ===== hdl/xpm_accum.sv =====
// ----------------------------------------------------------------------------
// xpm_accum
// Counts XNOR matches of one word pair, adds the bipolar product to the
// saturating running sum and holds the finished sum of a last word.
// ----------------------------------------------------------------------------
module xpm_accum (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  logic [xpm_pkg::WORD_BITS-1:0]     weight_word,
   input  logic [xpm_pkg::WORD_BITS-1:0]     act_word,
   input  logic [xpm_pkg::SCALE_W-1:0]       scale_q,
   input  logic                              last,
   input  logic                              out_free,
   output logic                              item_taken,
   output xpm_pkg::sum_stage_type            stage
);

   localparam logic signed [xpm_pkg::ACC_W-1:0] SumMax = xpm_pkg::ACC_W'(xpm_pkg::SUM_BOUND);
   localparam logic signed [xpm_pkg::ACC_W-1:0] SumMin = -SumMax;
   localparam int PadW = xpm_pkg::ACC_W - xpm_pkg::ONES_W - 1;

   logic signed [xpm_pkg::DOT_W-1:0] run_sum_ff, run_sum_in;
   xpm_pkg::sum_stage_type           stage_ff, stage_in;
   logic [xpm_pkg::ONES_W-1:0]       ones;
   logic signed [xpm_pkg::ACC_W-1:0] raw_sum;
   logic signed [xpm_pkg::DOT_W-1:0] sat_sum;
   logic                             stage_free;

   assign stage_free = !stage_ff.valid || out_free;
   assign item_taken = item_valid && (!last || stage_free);

   always_comb begin
      ones    = xpm_pkg::ONES_W'($countones(~(weight_word ^ act_word)));
      raw_sum = xpm_pkg::ACC_W'(run_sum_ff) + $signed({{PadW{1'b0}}, ones, 1'b0})
                - xpm_pkg::ACC_W'(xpm_pkg::WORD_BITS);
      if (raw_sum > SumMax) begin
         sat_sum = xpm_pkg::DOT_W'(SumMax);
      end else if (raw_sum < SumMin) begin
         sat_sum = xpm_pkg::DOT_W'(SumMin);
      end else begin
         sat_sum = raw_sum[xpm_pkg::DOT_W-1:0];
      end
   end

   always_comb begin
      run_sum_in = run_sum_ff;
      stage_in   = stage_ff;
      if (out_free) begin
         stage_in.valid = 1'b0;
      end
      if (item_taken) begin
         run_sum_in = last ? '0 : sat_sum;
         if (last) begin
            stage_in.valid   = 1'b1;
            stage_in.dot_sum = sat_sum;
            stage_in.scale_q = scale_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff     <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         run_sum_ff     <= run_sum_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.dot_sum <= stage_in.dot_sum;
      stage_ff.scale_q <= stage_in.scale_q;
   end

   assign stage = stage_ff;

endmodule

// ===== hdl/xpm_scale.sv =====
// ----------------------------------------------------------------------------
// xpm_scale
// Multiplies the finished sum by the filter scale and holds the result
// until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module xpm_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  xpm_pkg::sum_stage_type stage,
   output logic                   out_free,
   xpm_rsp_if.source              rsp
);

   localparam int PadW = xpm_pkg::PROD_W - xpm_pkg::SCALE_W;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [xpm_pkg::DOT_W-1:0]    dot_sum_ff, dot_sum_in;
   logic signed [xpm_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic signed [xpm_pkg::PROD_W-1:0]   sum_ext;
   logic signed [xpm_pkg::PROD_W-1:0]   scale_ext;
   logic signed [xpm_pkg::PROD_W-1:0]   product;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign sum_ext   = xpm_pkg::PROD_W'(stage.dot_sum);
   assign scale_ext = $signed({{PadW{1'b0}}, stage.scale_q});
   assign product   = sum_ext * scale_ext;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      dot_sum_in   = dot_sum_ff;
      scaled_in    = scaled_ff;
      if (out_free) begin
         rsp_valid_in = stage.valid;
         dot_sum_in   = stage.dot_sum;
         scaled_in    = product[xpm_pkg::SCALED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      dot_sum_ff <= dot_sum_in;
      scaled_ff  <= scaled_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.dot_sum       = dot_sum_ff;
   assign rsp.scaled_result = scaled_ff;

endmodule

// ===== hdl/xnor_popcount_mac_scaled.sv =====
// ----------------------------------------------------------------------------
// xnor_popcount_mac_scaled
// Binary-network dot-product engine with saturating sum and output scaling.
// ----------------------------------------------------------------------------
// Each transfer on req_chan brings one 32-bit weight word, one 32-bit
// activation word, the filter scale in unsigned Q2.14 and a last flag.
// The block adds 2*popcount(XNOR) - 32 to a running sum that saturates
// at plus or minus 131072. A word with last set closes the dot product:
// one transfer on rsp_chan then carries the sum and the sum times the
// scale in signed Q20.14, and the running sum starts again from zero.
// Words without last produce no transfer on rsp_chan.
// The path is an input register, an accumulate stage and a multiply
// stage with the result register, which a finished sum passes in turn.
// One word is taken every cycle unless a last word waits for a free
// accumulate stage; the running-sum add is the loop that sets that rate.
// When rsp_chan stalls, the result register holds and words that are
// not last keep flowing; a last word waits while a second sum is held.
// Synchronous reset clears the running sum and all pending items.
// ----------------------------------------------------------------------------
module xnor_popcount_mac_scaled (
   input  logic       clock,
   input  logic       reset,
   xpm_req_if.sink    req_chan,
   xpm_rsp_if.source  rsp_chan
);

   logic                              in_valid_ff, in_valid_in;
   logic [xpm_pkg::WORD_BITS-1:0]     weight_ff, weight_in;
   logic [xpm_pkg::WORD_BITS-1:0]     act_ff, act_in;
   logic [xpm_pkg::SCALE_W-1:0]       scale_ff, scale_in;
   logic                              last_ff, last_in;
   logic                              item_taken;
   logic                              out_free;
   xpm_pkg::sum_stage_type            stage;

   assign req_chan.ready = !in_valid_ff || item_taken;

   always_comb begin
      in_valid_in = in_valid_ff && !item_taken;
      weight_in   = weight_ff;
      act_in      = act_ff;
      scale_in    = scale_ff;
      last_in     = last_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         weight_in   = req_chan.weight_word;
         act_in      = req_chan.act_word;
         scale_in    = req_chan.scale_q;
         last_in     = req_chan.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      weight_ff <= weight_in;
      act_ff    <= act_in;
      scale_ff  <= scale_in;
      last_ff   <= last_in;
   end

   xpm_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (in_valid_ff),
      .weight_word (weight_ff),
      .act_word    (act_ff),
      .scale_q     (scale_ff),
      .last        (last_ff),
      .out_free    (out_free),
      .item_taken  (item_taken),
      .stage       (stage)
   );

   xpm_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .out_free (out_free),
      .rsp      (rsp_chan)
   );

endmodule
